>>> src/sqb_pkg.sv
// Shared types, sizes and codes for the sprite quad batcher.
`default_nettype none
package sqb_pkg;

  // Batch limits.
  localparam int MAX_QUADS = 1024;
  localparam int MAX_SLOTS = 32;

  // Field widths.
  localparam int COORD_W = 24;
  localparam int COLOR_W = 32;
  localparam int TEX_W   = 32;
  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int QUAD_W  = 11;
  localparam int OVF_W   = 16;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Request modes.
  typedef enum logic [1:0] {
    MODE_SPRITE = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_OVF    = 2'd3
  } mode_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_BIND   = 2'd1,
    KIND_DRAW   = 2'd2,
    KIND_OVF    = 2'd3
  } kind_t;

  // Texture coordinates per corner, packed as {u, v}.
  localparam logic [1:0] SPR_UV [4] = '{2'b01, 2'b11, 2'b10, 2'b00};
  localparam logic [1:0] SQ_UV  [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

  // Classified request as it waits in the queue; edges are already saturated.
  typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] z;
    logic [COLOR_W-1:0] color;
    logic [TEX_W-1:0]   tex;
  } q_entry_t;

  // One result item.
  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] vert_x;
    logic [COORD_W-1:0] vert_y;
    logic [COORD_W-1:0] vert_z;
    logic [COLOR_W-1:0] vert_color;
    logic               tex_u;
    logic               tex_v;
    logic [SLOT_W-1:0]  slot_index;
    logic [TEX_W-1:0]   bound_texture;
    logic [QUAD_W-1:0]  batch_quads;
    logic [OVF_W-1:0]   overflow_total;
    logic               last;
  } out_item_t;

endpackage
`default_nettype wire

>>> src/sqb_front.sv
// Front end: classifies a request and computes its saturated quad edges.
`default_nettype none
module sqb_front (
  input  wire logic [1:0]                  in_mode,
  input  wire logic [sqb_pkg::COORD_W-1:0] in_pos_x,
  input  wire logic [sqb_pkg::COORD_W-1:0] in_pos_y,
  input  wire logic [sqb_pkg::COORD_W-1:0] in_pos_z,
  input  wire logic [sqb_pkg::COORD_W-1:0] in_size_x,
  input  wire logic [sqb_pkg::COORD_W-1:0] in_size_y,
  input  wire logic [sqb_pkg::COLOR_W-1:0] in_color_rgba,
  input  wire logic [sqb_pkg::TEX_W-1:0]   in_texture_id,
  output sqb_pkg::q_entry_t                entry
);
  import sqb_pkg::*;

  // Signed add that clamps to the coordinate range.
  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      return s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return s[COORD_W-1:0];
  endfunction

  // Pack the request with both edges of each axis.
  always_comb begin
    entry.mode  = mode_t'(in_mode);
    entry.x0    = in_pos_x;
    entry.x1    = sat_add(in_pos_x, in_size_x);
    entry.y0    = in_pos_y;
    entry.y1    = sat_add(in_pos_y, in_size_y);
    entry.z     = in_pos_z;
    entry.color = in_color_rgba;
    entry.tex   = in_texture_id;
  end

endmodule
`default_nettype wire

>>> src/sqb_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none
module sqb_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  sqb_pkg::q_entry_t push_data,
  output logic              full,
  input  wire logic         pop,
  output sqb_pkg::q_entry_t head,
  output logic              empty
);
  import sqb_pkg::*;

  q_entry_t            mem_r [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == QCNT_W'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/sqb_back.sv
// Back end: slot lookup, batch flushes, overflow reports and vertex emission into the output register.
`default_nettype none
module sqb_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [sqb_pkg::TEX_W-1:0] white_tex,
  input  sqb_pkg::q_entry_t              q_head,
  input  wire logic                      q_empty,
  output logic                           q_pop,
  output sqb_pkg::out_item_t             out_item,
  output logic                           out_valid,
  input  wire logic                      out_ready
);
  import sqb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIND,
    S_DRAW,
    S_MATCH,
    S_SLOT,
    S_VERT,
    S_OVF
  } state_t;

  state_t               state_r;
  q_entry_t             cur_r;
  logic                 forced_r;
  logic [SLOT_W-1:0]    bind_idx_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [1:0]           vert_k_r;
  logic [MAX_SLOTS-1:0] match_r;
  logic [CNT_W-1:0]     slots_used_r;
  logic [QUAD_W-1:0]    quads_r;
  logic [OVF_W-1:0]     ovf_r;
  logic [TEX_W-1:0]     slot_table_r [MAX_SLOTS];
  out_item_t            out_r;
  logic                 out_valid_r;

  logic                 out_load;
  logic                 batch_full;
  logic                 emitting;
  logic                 claim_we;
  logic [MAX_SLOTS-1:0] match_vec;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;
  logic [1:0]           uv;
  out_item_t            emit_item;

  assign out_item  = out_r;
  assign out_valid = out_valid_r;
  assign out_load  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign batch_full = (quads_r >= QUAD_W'(MAX_QUADS)) ||
                      (slots_used_r >= CNT_W'(MAX_SLOTS));
  assign emitting  = (state_r == S_BIND) || (state_r == S_DRAW) ||
                     (state_r == S_VERT) || (state_r == S_OVF);
  assign claim_we  = (state_r == S_SLOT) && !hit;

  // Compare the texture against every live slot; slot zero never matches.
  always_comb begin
    match_vec = '0;
    for (int i = 1; i < MAX_SLOTS; i++) begin
      match_vec[i] = (CNT_W'(i) < slots_used_r) && (slot_table_r[i] == cur_r.tex);
    end
  end

  // Live slot ids are unique, so the matches form at most one hot bit.
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (match_r[i]) begin
        hit_slot = hit_slot | SLOT_W'(i);
      end
    end
  end
  assign hit = |match_r;

  // Build the result for the current state.
  always_comb begin
    uv        = (cur_r.mode == MODE_SPRITE) ? SPR_UV[vert_k_r] : SQ_UV[vert_k_r];
    emit_item = '0;
    case (state_r)
      S_BIND: begin
        emit_item.kind          = KIND_BIND;
        emit_item.slot_index    = bind_idx_r;
        emit_item.bound_texture = (bind_idx_r == '0) ? white_tex : slot_table_r[bind_idx_r];
      end
      S_DRAW: begin
        emit_item.kind        = KIND_DRAW;
        emit_item.batch_quads = quads_r;
        emit_item.last        = !forced_r;
      end
      S_VERT: begin
        emit_item.kind       = KIND_VERTEX;
        emit_item.vert_x     = (vert_k_r == 2'd1 || vert_k_r == 2'd2) ? cur_r.x1 : cur_r.x0;
        emit_item.vert_y     = vert_k_r[1] ? cur_r.y1 : cur_r.y0;
        emit_item.vert_z     = cur_r.z;
        emit_item.vert_color = cur_r.color;
        emit_item.tex_u      = uv[1];
        emit_item.tex_v      = uv[0];
        emit_item.slot_index = slot_r;
        emit_item.last       = (vert_k_r == 2'd3);
      end
      S_OVF: begin
        emit_item.kind           = KIND_OVF;
        emit_item.overflow_total = ovf_r;
        emit_item.last           = 1'b1;
      end
      default: begin
        emit_item = '0;
      end
    endcase
  end

  // Slot table: written when a sprite claims a new slot.
  always_ff @(posedge clk) begin
    if (claim_we) begin
      slot_table_r[slots_used_r[SLOT_W-1:0]] <= cur_r.tex;
    end
  end

  // Payload registers of the current request.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (state_r == S_MATCH) begin
      match_r <= match_vec;
    end
    if (out_load && emitting) begin
      out_r <= emit_item;
    end
  end

  // Sequencer, batch counters and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      forced_r     <= 1'b0;
      bind_idx_r   <= '0;
      slot_r       <= '0;
      vert_k_r     <= '0;
      slots_used_r <= CNT_W'(1);
      quads_r      <= '0;
      ovf_r        <= '0;
    end else begin
      if (out_load && emitting) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            forced_r   <= 1'b0;
            bind_idx_r <= '0;
            vert_k_r   <= '0;
            slot_r     <= '0;
            case (q_head.mode)
              MODE_FLUSH: begin
                state_r <= S_BIND;
              end
              MODE_OVF: begin
                state_r <= S_OVF;
              end
              default: begin
                if (batch_full) begin
                  // Forced flush before the quad.
                  forced_r <= 1'b1;
                  if (ovf_r != '1) begin
                    ovf_r <= ovf_r + OVF_W'(1);
                  end
                  state_r <= S_BIND;
                end else if (q_head.mode == MODE_SPRITE) begin
                  state_r <= S_MATCH;
                end else begin
                  state_r <= S_VERT;
                end
              end
            endcase
          end
        end
        S_BIND: begin
          if (out_load) begin
            if (CNT_W'(bind_idx_r) == slots_used_r - CNT_W'(1)) begin
              state_r <= S_DRAW;
            end else begin
              bind_idx_r <= bind_idx_r + SLOT_W'(1);
            end
          end
        end
        S_DRAW: begin
          if (out_load) begin
            quads_r      <= '0;
            slots_used_r <= CNT_W'(1);
            if (!forced_r) begin
              state_r <= S_IDLE;
            end else if (cur_r.mode == MODE_SPRITE) begin
              state_r <= S_MATCH;
            end else begin
              state_r <= S_VERT;
            end
          end
        end
        S_MATCH: begin
          state_r <= S_SLOT;
        end
        S_SLOT: begin
          // Reuse a matching slot or claim the next free one.
          if (hit) begin
            slot_r <= hit_slot;
          end else begin
            slot_r       <= slots_used_r[SLOT_W-1:0];
            slots_used_r <= slots_used_r + CNT_W'(1);
          end
          state_r <= S_VERT;
        end
        S_VERT: begin
          if (out_load) begin
            if (vert_k_r == 2'd3) begin
              quads_r <= quads_r + QUAD_W'(1);
              state_r <= S_IDLE;
            end else begin
              vert_k_r <= vert_k_r + 2'd1;
            end
          end
        end
        S_OVF: begin
          if (out_load) begin
            ovf_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/sprite_quad_batcher.sv
// Sprite quad batcher: expands draw requests into vertices, slot binds and batch draws.
//
// Input channel (in_*): one request per transfer. Modes are textured sprite,
// untextured square, flush batch and read-and-clear of the overflow counter.
// Result channel (out_*): vertices, slot binds, draw records and overflow
// reports; out_last marks the final result of each request.
// Configuration channel (cfg_*): writes the white texture id bound in slot 0;
// it is always ready. It must be written only while the block is idle; the block
// itself does not enforce this. Requests pass a two-entry queue, so the input
// keeps taking transfers while the back end works. The back end handles one
// request at a time and emits at most one result per cycle: a square emits its
// four vertices, a sprite adds a slot compare and a slot claim step before them,
// a flush emits one bind per slot in use and then a draw record, and an overflow
// read emits one report. A forced flush adds its binds and draw ahead of the quad.
// A single output register holds each result; when the receiver stalls, the
// back end waits and the queue fills, then in_ready drops.
// Reset empties the queue and the output register, sets one slot in use, and
// clears the quad and overflow counts; slot entries need no clearing.
`default_nettype none
module sprite_quad_batcher (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sqb_pkg::TEX_W-1:0]           cfg_white_texture_id,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_mode,
  input  wire logic signed [sqb_pkg::COORD_W-1:0]  in_pos_x,
  input  wire logic signed [sqb_pkg::COORD_W-1:0]  in_pos_y,
  input  wire logic signed [sqb_pkg::COORD_W-1:0]  in_pos_z,
  input  wire logic signed [sqb_pkg::COORD_W-1:0]  in_size_x,
  input  wire logic signed [sqb_pkg::COORD_W-1:0]  in_size_y,
  input  wire logic [sqb_pkg::COLOR_W-1:0]         in_color_rgba,
  input  wire logic [sqb_pkg::TEX_W-1:0]           in_texture_id,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               out_kind,
  output logic signed [sqb_pkg::COORD_W-1:0]       out_vert_x,
  output logic signed [sqb_pkg::COORD_W-1:0]       out_vert_y,
  output logic signed [sqb_pkg::COORD_W-1:0]       out_vert_z,
  output logic [sqb_pkg::COLOR_W-1:0]              out_vert_color,
  output logic                                     out_tex_u,
  output logic                                     out_tex_v,
  output logic [sqb_pkg::SLOT_W-1:0]               out_slot_index,
  output logic [sqb_pkg::TEX_W-1:0]                out_bound_texture,
  output logic [sqb_pkg::QUAD_W-1:0]               out_batch_quads,
  output logic [sqb_pkg::OVF_W-1:0]                out_overflow_total,
  output logic                                     out_last
);
  import sqb_pkg::*;

  logic [TEX_W-1:0] white_tex_r;
  q_entry_t         front_entry;
  q_entry_t         q_head;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  out_item_t        item;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_tex_r <= '0;
    end else if (cfg_valid) begin
      white_tex_r <= cfg_white_texture_id;
    end
  end

  assign in_ready = !q_full;

  sqb_front u_front (
    .in_mode       (in_mode),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_size_x     (in_size_x),
    .in_size_y     (in_size_y),
    .in_color_rgba (in_color_rgba),
    .in_texture_id (in_texture_id),
    .entry         (front_entry)
  );

  sqb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sqb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .white_tex (white_tex_r),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_item  (item),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // Result fields to ports.
  assign out_kind           = item.kind;
  assign out_vert_x         = item.vert_x;
  assign out_vert_y         = item.vert_y;
  assign out_vert_z         = item.vert_z;
  assign out_vert_color     = item.vert_color;
  assign out_tex_u          = item.tex_u;
  assign out_tex_v          = item.tex_v;
  assign out_slot_index     = item.slot_index;
  assign out_bound_texture  = item.bound_texture;
  assign out_batch_quads    = item.batch_quads;
  assign out_overflow_total = item.overflow_total;
  assign out_last           = item.last;

endmodule
`default_nettype wire
